/* rtl/lzss_block_decompressor_top_assert.svh */
// Assertion macros for the LZSS block decompressor.
`ifndef LZSS_BLOCK_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_BLOCK_DECOMPRESSOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LZSSBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzssbd: same-cycle check failed");
// next-cycle implication
`define LZSSBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzssbd: next-cycle check failed");
`else
`define LZSSBD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LZSSBD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/lzssbd_pkg.sv */
// Shared constants and types of the LZSS block decompressor.
`default_nettype none
package lzssbd_pkg;

  localparam int unsigned WindowSize = 4096;
  localparam int unsigned AddrW      = $clog2(WindowSize);
  localparam logic [AddrW-1:0] WinStart = AddrW'(WindowSize - 18);
  localparam logic [7:0] Space = 8'h20;
  localparam int unsigned LenW = 5;

  // command from the parser, qualified by item acceptance
  typedef struct packed {
    logic             emit;   // one byte straight to the output
    logic             wr;     // and into the window
    logic             clear;  // new LZSS block: reset window
    logic             copy;   // start a match copy
    logic [7:0]       data;
    logic [AddrW-1:0] src;
    logic [LenW-1:0]  len;
  } cmd_t;

  // output stage status
  typedef struct packed {
    logic can_emit;
    logic hold_busy;
  } oflow_t;

  // one byte towards the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } push_t;

endpackage
`default_nettype wire

/* rtl/lzssbd_parser.sv */
// Stream parser: headers, raw bytes, flag bytes, literals and match codes.
`default_nettype none
module lzssbd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              end_of_stream_i,
  output lzssbd_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] PhHdrHi   = 3'd0;
  localparam logic [2:0] PhHdrLo   = 3'd1;
  localparam logic [2:0] PhRaw     = 3'd2;
  localparam logic [2:0] PhFlag    = 3'd3;
  localparam logic [2:0] PhItem    = 3'd4;
  localparam logic [2:0] PhMatchHi = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  hdr_hi_q, hdr_hi_d;
  logic [7:0]  flags_q, flags_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  mlow_q, mlow_d;
  logic        stop_q, stop_d;

  logic [15:0] rem_dec;
  logic [15:0] count;
  logic [3:0]  fcnt_dec;
  logic [2:0]  after_ph;
  lzssbd_pkg::cmd_t cmd;

  always_comb begin
    rem_dec  = (rem_q != '0) ? rem_q - 16'd1 : '0;
    count    = {hdr_hi_q, data_byte_i};
    fcnt_dec = (fcnt_q != '0) ? fcnt_q - 4'd1 : '0;
    if (rem_dec == '0) begin
      after_ph = PhHdrHi;
    end else if (fcnt_dec == '0) begin
      after_ph = PhFlag;
    end else begin
      after_ph = PhItem;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    hdr_hi_d = hdr_hi_q;
    flags_d  = flags_q;
    fcnt_d   = fcnt_q;
    mlow_d   = mlow_q;
    stop_d   = stop_q;
    cmd      = '0;
    cmd.data = data_byte_i;
    cmd.src  = {data_byte_i[7:4], mlow_q};
    cmd.len  = lzssbd_pkg::LenW'(data_byte_i[3:0]) + lzssbd_pkg::LenW'(3);
    if (accept_i) begin
      if (!stop_q) begin
        unique case (phase_q)
          PhHdrLo: begin
            if (count == '0) begin
              stop_d  = 1'b1;
              phase_d = PhHdrHi;
            end else if (count[15]) begin
              rem_d   = ~count + 16'd1;
              phase_d = PhRaw;
            end else begin
              rem_d     = count;
              cmd.clear = 1'b1;
              fcnt_d    = '0;
              phase_d   = PhFlag;
            end
          end
          PhRaw: begin
            cmd.emit = 1'b1;
            rem_d    = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PhHdrHi;
            end
          end
          PhFlag: begin
            flags_d = data_byte_i;
            fcnt_d  = 4'd8;
            rem_d   = rem_dec;
            phase_d = (rem_dec == '0) ? PhHdrHi : PhItem;
          end
          PhItem: begin
            rem_d = rem_dec;
            if (flags_q[0]) begin
              cmd.emit = 1'b1;
              cmd.wr   = 1'b1;
              flags_d  = flags_q >> 1;
              fcnt_d   = fcnt_dec;
              phase_d  = after_ph;
            end else begin
              mlow_d  = data_byte_i;
              phase_d = PhMatchHi;
            end
          end
          PhMatchHi: begin
            rem_d    = rem_dec;
            cmd.copy = 1'b1;
            flags_d  = flags_q >> 1;
            fcnt_d   = fcnt_dec;
            phase_d  = after_ph;
          end
          default: begin
            hdr_hi_d = data_byte_i;
            phase_d  = PhHdrLo;
          end
        endcase
      end
      if (end_of_stream_i) begin
        phase_d = PhHdrHi;
        rem_d   = '0;
        fcnt_d  = '0;
        stop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdrHi;
      rem_q    <= '0;
      hdr_hi_q <= '0;
      flags_q  <= '0;
      fcnt_q   <= '0;
      mlow_q   <= '0;
      stop_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      hdr_hi_q <= hdr_hi_d;
      flags_q  <= flags_d;
      fcnt_q   <= fcnt_d;
      mlow_q   <= mlow_d;
      stop_q   <= stop_d;
    end
  end

  assign cmd_o = cmd;

endmodule
`default_nettype wire

/* rtl/lzssbd_window.sv */
// History window memory with the match copy engine.
`default_nettype none
module lzssbd_window (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzssbd_pkg::cmd_t   cmd_i,
  input  wire lzssbd_pkg::oflow_t oflow_i,
  output lzssbd_pkg::push_t      push_o,
  output logic                   busy_o
);

  localparam int unsigned AW = lzssbd_pkg::AddrW;
  localparam int unsigned LW = lzssbd_pkg::LenW;

  logic [7:0] mem [lzssbd_pkg::WindowSize];
  logic [7:0] rdata_q;

  logic [AW-1:0] wp_q, wp_d;
  logic [AW:0]   fill_q, fill_d;
  logic [AW-1:0] src_q, src_d;
  logic [LW-1:0] left_q, left_d;
  logic          pend_q, pend_d;
  logic          ok_q, ok_d;
  logic          fwd_q, fwd_d;
  logic [7:0]    fwd_byte_q, fwd_byte_d;
  logic          last_q, last_d;

  logic          issue;
  logic          we;
  logic [7:0]    wdata;
  logic [7:0]    copy_byte;
  logic [AW-1:0] offs;

  always_comb begin
    issue     = (left_q != '0) && !oflow_i.hold_busy && !(pend_q && !oflow_i.can_emit);
    copy_byte = fwd_q ? fwd_byte_q : (ok_q ? rdata_q : lzssbd_pkg::Space);
    we        = pend_q || (cmd_i.emit && cmd_i.wr);
    wdata     = pend_q ? copy_byte : cmd_i.data;
    // entries written since the last clear lie in [WinStart, WinStart + fill)
    offs      = src_q - lzssbd_pkg::WinStart;

    wp_d       = wp_q;
    fill_d     = fill_q;
    src_d      = src_q;
    left_d     = left_q;
    pend_d     = issue;
    ok_d       = ok_q;
    fwd_d      = fwd_q;
    fwd_byte_d = fwd_byte_q;
    last_d     = last_q;

    if (we) begin
      wp_d = wp_q + AW'(1);
      if (!fill_q[AW]) begin
        fill_d = fill_q + (AW+1)'(1);
      end
    end
    if (issue) begin
      ok_d       = {1'b0, offs} < fill_q;
      fwd_d      = we && (wp_q == src_q);
      fwd_byte_d = wdata;
      last_d     = (left_q == LW'(1));
      src_d      = src_q + AW'(1);
      left_d     = left_q - LW'(1);
    end
    if (cmd_i.clear) begin
      wp_d   = lzssbd_pkg::WinStart;
      fill_d = '0;
    end
    if (cmd_i.copy) begin
      src_d  = cmd_i.src;
      left_d = cmd_i.len;
    end

    push_o.valid = pend_q || cmd_i.emit;
    push_o.data  = pend_q ? copy_byte : cmd_i.data;
    push_o.last  = pend_q ? last_q : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= lzssbd_pkg::WinStart;
      fill_q <= '0;
      left_q <= '0;
      pend_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      left_q <= left_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    ok_q       <= ok_d;
    fwd_q      <= fwd_d;
    fwd_byte_q <= fwd_byte_d;
    last_q     <= last_d;
  end

  assign busy_o = (left_q != '0) || pend_q;

endmodule
`default_nettype wire

/* rtl/lzssbd_out.sv */
// Output register with a one-entry hold stage.
`default_nettype none
module lzssbd_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzssbd_pkg::push_t push_i,
  output lzssbd_pkg::oflow_t     oflow_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o
);

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       ol_q, ol_d;
  logic       hv_q, hv_d;
  logic [7:0] hb_q, hb_d;
  logic       hl_q, hl_d;
  logic       can_emit;

  always_comb begin
    can_emit = !ov_q || out_ready_i;
    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    hv_d = hv_q;
    hb_d = hb_q;
    hl_d = hl_q;
    if (hv_q) begin
      if (can_emit) begin
        ov_d = 1'b1;
        ob_d = hb_q;
        ol_d = hl_q;
        hv_d = 1'b0;
      end
    end else if (push_i.valid) begin
      if (can_emit) begin
        ov_d = 1'b1;
        ob_d = push_i.data;
        ol_d = push_i.last;
      end else begin
        hv_d = 1'b1;
        hb_d = push_i.data;
        hl_d = push_i.last;
      end
    end else if (can_emit) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      hv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      hv_q <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    hb_q <= hb_d;
    hl_q <= hl_d;
  end

  assign oflow_o.can_emit  = can_emit;
  assign oflow_o.hold_busy = hv_q;
  assign out_valid_o       = ov_q;
  assign out_byte_o        = ob_q;
  assign last_of_run_o     = ol_q;

endmodule
`default_nettype wire

/* rtl/lzss_block_decompressor_top.sv */
// LZSS block decompressor, 4096-byte window: top level.
// Header, flag, raw and literal items need no copy work; a literal or raw byte goes to
// the output register, or to the hold stage while the output is stalled.
// A match item copies 3..18 bytes, one byte per cycle while the output stage can take them;
// each is read into a register, then written back via the single window memory and pushed.
// Reset is asynchronous, active low; the window reads as spaces via a fill count,
// so no clearing pass is needed after reset or at an LZSS block header.
`default_nettype none
`include "lzss_block_decompressor_top_assert.svh"
module lzss_block_decompressor_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  logic               accept;
  logic               win_busy;
  lzssbd_pkg::cmd_t   cmd;
  lzssbd_pkg::oflow_t oflow;
  lzssbd_pkg::push_t  push;

  // A new item is taken only once any match copy has fully written back and
  // the hold stage is free, so an item's bytes always find a slot.
  assign in_ready_o = !win_busy && !oflow.hold_busy;
  assign accept     = in_valid_i && in_ready_o;

  // Parser: block headers, flags and match codes -> commands.
  lzssbd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cmd_o           (cmd)
  );

  // Window memory and copy engine; forwards a byte written in the cycle it is read.
  lzssbd_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .oflow_i (oflow),
    .push_o  (push),
    .busy_o  (win_busy)
  );

  // Output register plus hold stage; the copy engine pauses while it is full.
  lzssbd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .oflow_o       (oflow),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // no item enters while a copy is in flight
  `LZSSBD_ASSERT_IMP(a_accept_idle, clk_i, rst_ni, accept, !win_busy)
  // a byte is never pushed onto an occupied hold stage
  `LZSSBD_ASSERT_IMP(a_push_no_hold, clk_i, rst_ni, push.valid, !oflow.hold_busy)
  // an accepted match keeps the engine busy on the next cycle
  `LZSSBD_ASSERT_NXT(a_copy_busy, clk_i, rst_ni, accept && cmd.copy, win_busy)

endmodule
`default_nettype wire
